// ===== rtl/sorted_symbol_predecessor_lookup_defines.svh =====
// Assertion macros used by the table controller.
`ifndef SORTED_SYMBOL_PREDECESSOR_LOOKUP_DEFINES_SVH
`define SORTED_SYMBOL_PREDECESSOR_LOOKUP_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define SSPL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SSPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SSPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sspl_pkg.sv =====
`timescale 1ns / 1ps

package sspl_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    // Request codes
    localparam logic [1:0] REQ_LOAD       = 2'd0;
    localparam logic [1:0] REQ_LOOKUP     = 2'd1;
    localparam logic [1:0] REQ_CLEAR      = 2'd2;
    localparam logic [1:0] REQ_LOOKUP_ALT = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_EXACT   = 3'd0;
    localparam logic [2:0] STAT_BELOW   = 3'd1;
    localparam logic [2:0] STAT_BEFORE  = 3'd2;
    localparam logic [2:0] STAT_EMPTY   = 3'd3;
    localparam logic [2:0] STAT_LOADED  = 3'd4;
    localparam logic [2:0] STAT_FULL    = 3'd5;
    localparam logic [2:0] STAT_CLEARED = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] addr_offset;
        logic [31:0] name_ref;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_ref;
        logic [31:0] displacement;
    } t_res;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] name_ref;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_FETCH,
        ST_LOOK_END,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/sorted_symbol_predecessor_lookup.sv =====
`timescale 1ns / 1ps
// Lookup: decode, S probes (read, compare), fetch, look-end; S <= ceil(log2(count+1)).
// A lookup below the first entry skips fetch and look-end. Load: decode, S probes, a shift
// read/write per entry moved up to open the slot, a last shift read, insert. A clear, a
// full-table load and an empty-table lookup go from decode to done. One request at a time:
// the next is accepted after the result enters the output stage; stalls hold the controller.
// Reset (synchronous, active low) empties the table and the output stage; no clearing pass.
module sorted_symbol_predecessor_lookup #(
    parameter int TABLE_ENTRIES = sspl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sspl_pkg::t_req i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output sspl_pkg::t_res o_data
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic             res_valid;
    logic             res_take;
    sspl_pkg::t_res   res;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    sspl_pkg::t_entry mem_wdata;
    logic             mem_re;
    logic [IW-1:0]    mem_raddr;
    sspl_pkg::t_entry mem_rdata;

    logic             r_out_valid;
    sspl_pkg::t_res   r_out;

    sspl_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_data),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    sspl_mem #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // take a new beat when the stage is empty or being drained
    assign res_take = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/sspl_mem.sv =====
`timescale 1ns / 1ps

module sspl_mem #(
    parameter int TABLE_ENTRIES = sspl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_waddr,
    input  sspl_pkg::t_entry                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_raddr,
    output sspl_pkg::t_entry                 o_rdata
);

    sspl_pkg::t_entry r_mem [TABLE_ENTRIES];
    sspl_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sspl_ctrl.sv =====
`timescale 1ns / 1ps
`include "sorted_symbol_predecessor_lookup_defines.svh"

module sspl_ctrl #(
    parameter int TABLE_ENTRIES = sspl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  sspl_pkg::t_req                   i_req,
    output logic                             o_res_valid,
    input  logic                             i_res_take,
    output sspl_pkg::t_res                   o_res,
    output logic                             o_mem_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_mem_waddr,
    output sspl_pkg::t_entry                 o_mem_wdata,
    output logic                             o_mem_re,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_mem_raddr,
    input  sspl_pkg::t_entry                 i_mem_rdata
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    sspl_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_idx, n_idx;
    sspl_pkg::t_req   r_req, n_req;
    sspl_pkg::t_res   r_res, n_res;

    logic [CW-1:0] mid;
    logic [CW-1:0] mid_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] lo_dec;
    logic          key_le;
    logic [CW-1:0] cmp_lo;
    logic [CW-1:0] cmp_hi;
    logic          search_done;
    logic          is_load;
    logic          is_clear;

    assign is_load  = (r_req.req_type == sspl_pkg::REQ_LOAD);
    assign is_clear = (r_req.req_type == sspl_pkg::REQ_CLEAR);

    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign mid_inc = mid + CW'(1);
    assign idx_dec = r_idx - CW'(1);
    assign lo_dec  = r_lo - CW'(1);
    assign key_le  = (i_mem_rdata.key <= r_req.addr_offset);
    assign cmp_lo  = key_le ? mid_inc : r_lo;
    assign cmp_hi  = key_le ? r_hi : mid;
    assign search_done = (cmp_lo == cmp_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sspl_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_idx <= n_idx;
        r_req <= n_req;
        r_res <= n_res;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sspl_pkg::ST_IDLE: begin
                if (i_valid) n_state = sspl_pkg::ST_DECODE;
            end
            sspl_pkg::ST_DECODE: begin
                priority if (is_clear) begin
                    n_state = sspl_pkg::ST_DONE;
                end else if (is_load) begin
                    priority if (r_count == FULL_COUNT) n_state = sspl_pkg::ST_DONE;
                    else if (r_count == '0)             n_state = sspl_pkg::ST_SHIFT_RD;
                    else                                n_state = sspl_pkg::ST_SEARCH_RD;
                end else begin
                    if (r_count == '0) n_state = sspl_pkg::ST_DONE;
                    else               n_state = sspl_pkg::ST_SEARCH_RD;
                end
            end
            sspl_pkg::ST_SEARCH_RD: n_state = sspl_pkg::ST_SEARCH_CMP;
            sspl_pkg::ST_SEARCH_CMP: begin
                priority if (!search_done) n_state = sspl_pkg::ST_SEARCH_RD;
                else if (is_load)          n_state = sspl_pkg::ST_SHIFT_RD;
                else if (cmp_lo == '0)     n_state = sspl_pkg::ST_DONE;
                else                       n_state = sspl_pkg::ST_FETCH;
            end
            sspl_pkg::ST_SHIFT_RD: begin
                if (r_idx == r_lo) n_state = sspl_pkg::ST_INSERT;
                else               n_state = sspl_pkg::ST_SHIFT_WR;
            end
            sspl_pkg::ST_SHIFT_WR: n_state = sspl_pkg::ST_SHIFT_RD;
            sspl_pkg::ST_INSERT:   n_state = sspl_pkg::ST_DONE;
            sspl_pkg::ST_FETCH:    n_state = sspl_pkg::ST_LOOK_END;
            sspl_pkg::ST_LOOK_END: n_state = sspl_pkg::ST_DONE;
            sspl_pkg::ST_DONE: begin
                if (i_res_take) n_state = sspl_pkg::ST_IDLE;
            end
            default: n_state = sspl_pkg::ST_IDLE;
        endcase
    end

    // Datapath registers
    always_comb begin
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_idx   = r_idx;
        n_req   = r_req;
        n_res   = r_res;
        unique case (r_state)
            sspl_pkg::ST_IDLE: begin
                if (i_valid) n_req = i_req;
            end
            sspl_pkg::ST_DECODE: begin
                n_lo  = '0;
                n_hi  = r_count;
                n_idx = r_count;
                n_res = '0;
                priority if (is_clear) begin
                    n_count      = '0;
                    n_res.status = sspl_pkg::STAT_CLEARED;
                end else if (is_load) begin
                    if (r_count == FULL_COUNT) n_res.status = sspl_pkg::STAT_FULL;
                end else begin
                    if (r_count == '0) begin
                        n_res.status       = sspl_pkg::STAT_EMPTY;
                        n_res.displacement = r_req.addr_offset;
                    end
                end
            end
            sspl_pkg::ST_SEARCH_CMP: begin
                n_lo = cmp_lo;
                n_hi = cmp_hi;
                if (search_done && !is_load && cmp_lo == '0) begin
                    n_res.status = sspl_pkg::STAT_BEFORE;
                end
            end
            sspl_pkg::ST_SHIFT_WR: n_idx = idx_dec;
            sspl_pkg::ST_INSERT: begin
                n_count      = r_count + CW'(1);
                n_res.status = sspl_pkg::STAT_LOADED;
            end
            sspl_pkg::ST_LOOK_END: begin
                n_res.status       = (i_mem_rdata.key == r_req.addr_offset) ?
                                     sspl_pkg::STAT_EXACT : sspl_pkg::STAT_BELOW;
                n_res.found_ref    = i_mem_rdata.name_ref;
                n_res.displacement = r_req.addr_offset - i_mem_rdata.key;
            end
            default: begin
            end
        endcase
    end

    // Outputs and table accesses
    always_comb begin
        o_stall     = (r_state != sspl_pkg::ST_IDLE);
        o_res_valid = (r_state == sspl_pkg::ST_DONE);
        o_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[IW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = mid[IW-1:0];
        unique case (r_state)
            sspl_pkg::ST_SEARCH_RD: o_mem_re = 1'b1;
            sspl_pkg::ST_SHIFT_RD: begin
                o_mem_re    = (r_idx != r_lo);
                o_mem_raddr = idx_dec[IW-1:0];
            end
            // move the fetched entry one place up
            sspl_pkg::ST_SHIFT_WR: o_mem_we = 1'b1;
            sspl_pkg::ST_INSERT: begin
                o_mem_we             = 1'b1;
                o_mem_waddr          = r_lo[IW-1:0];
                o_mem_wdata.key      = r_req.addr_offset;
                o_mem_wdata.name_ref = r_req.name_ref;
            end
            sspl_pkg::ST_FETCH: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = lo_dec[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    `SSPL_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT, "entry count above table size")
    `SSPL_ASSERT_IMP(a_search_range, i_clk, i_rst_n, (r_state == sspl_pkg::ST_SEARCH_RD) || (r_state == sspl_pkg::ST_SEARCH_CMP), r_lo < r_hi, "search range empty")
    `SSPL_ASSERT_IMP(a_write_not_full, i_clk, i_rst_n, o_mem_we, r_count < FULL_COUNT, "table write while full")
    `SSPL_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, r_state == sspl_pkg::ST_INSERT, r_count == $past(r_count) + CW'(1), "insert did not bump count")

endmodule

// ===== bench/tb_sorted_symbol_predecessor_lookup.sv =====
`timescale 1ns / 1ps

module tb_sorted_symbol_predecessor_lookup;

    localparam int ENTRIES = sspl_pkg::TABLE_ENTRIES_DEF;
    localparam int SETTLE_CYCLES = 600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    sspl_pkg::t_req i_data = '0;
    logic o_stall;
    logic o_valid;
    sspl_pkg::t_res o_data;

    sorted_symbol_predecessor_lookup #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the sorted table
    logic [31:0] tbl_keys [ENTRIES];
    logic [31:0] tbl_refs [ENTRIES];
    int tbl_count = 0;

    sspl_pkg::t_req req_backlog[$];
    sspl_pkg::t_res pending_outcomes[$];
    sspl_pkg::t_res want;
    int fault_count = 0;
    int cyc = 0;
    logic [31:0] key_pool [12];

    // One long stretch where neither side idles
    wire quiet = (cyc >= 4000) && (cyc < 14000);

    always @(posedge i_clk) cyc <= cyc + 1;

    function automatic sspl_pkg::t_res lookup_outcome(sspl_pkg::t_req r);
        sspl_pkg::t_res o;
        int n;
        int i;
        logic [31:0] k;
        o = '0;
        n = 0;
        while (n < tbl_count && tbl_keys[n] <= r.addr_offset) n++;
        case (r.req_type)
            sspl_pkg::REQ_LOAD: begin
                if (tbl_count >= ENTRIES) begin
                    o.status = sspl_pkg::STAT_FULL;
                end else begin
                    // equal keys land after existing ones
                    for (i = tbl_count; i > n; i--) begin
                        tbl_keys[i] = tbl_keys[i - 1];
                        tbl_refs[i] = tbl_refs[i - 1];
                    end
                    tbl_keys[n] = r.addr_offset;
                    tbl_refs[n] = r.name_ref;
                    tbl_count++;
                    o.status = sspl_pkg::STAT_LOADED;
                end
            end
            sspl_pkg::REQ_CLEAR: begin
                tbl_count = 0;
                o.status = sspl_pkg::STAT_CLEARED;
            end
            default: begin
                if (tbl_count == 0) begin
                    o.status = sspl_pkg::STAT_EMPTY;
                    o.displacement = r.addr_offset;
                end else if (n == 0) begin
                    o.status = sspl_pkg::STAT_BEFORE;
                end else begin
                    k = tbl_keys[n - 1];
                    o.status = (k == r.addr_offset) ? sspl_pkg::STAT_EXACT
                                                    : sspl_pkg::STAT_BELOW;
                    o.found_ref = tbl_refs[n - 1];
                    o.displacement = r.addr_offset - k;
                end
            end
        endcase
        return o;
    endfunction

    task automatic report_fault(string what, sspl_pkg::t_res exp_res, sspl_pkg::t_res got);
        if (fault_count < 10)
            $display("%0t %s: expected st=%0d ref=%h disp=%h, got st=%0d ref=%h disp=%h",
                     $time, what, exp_res.status, exp_res.found_ref, exp_res.displacement,
                     got.status, got.found_ref, got.displacement);
        fault_count++;
    endtask

    // Request side: predict on accept, then offer the next beat or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                pending_outcomes.push_back(lookup_outcome(i_data));
            if (!i_valid || !o_stall) begin
                if (req_backlog.size() != 0 && (quiet || $urandom_range(99) >= 37)) begin
                    i_valid <= 1'b1;
                    i_data <= req_backlog.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_outcomes.size() == 0) begin
                    report_fault("unexpected result", '0, o_data);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (o_data.status !== want.status || o_data.found_ref !== want.found_ref
                            || o_data.displacement !== want.displacement)
                        report_fault("mismatch", want, o_data);
                end
            end
            i_stall <= !quiet && ($urandom_range(99) < 37);
        end
    end

    task automatic add_req(logic [1:0] kind, logic [31:0] addr, logic [31:0] nref);
        sspl_pkg::t_req r;
        r.req_type = kind;
        r.addr_offset = addr;
        r.name_ref = nref;
        req_backlog.push_back(r);
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(1) == 0) return key_pool[$urandom_range(11)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_probe();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return key_pool[$urandom_range(11)];
        if (sel < 60) return key_pool[$urandom_range(11)] + $urandom_range(1, 255);
        if (sel < 70) return key_pool[$urandom_range(11)] - $urandom_range(1, 255);
        if (sel < 90) return $urandom;
        return ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [1:0] probe_code();
        return ($urandom_range(4) == 0) ? sspl_pkg::REQ_LOOKUP_ALT : sspl_pkg::REQ_LOOKUP;
    endfunction

    initial begin
        int target;
        int nload;
        int nprobe;
        int i;
        bit filled;

        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        for (i = 3; i < 12; i++) key_pool[i] = $urandom;

        // Directed: empty table, duplicates, extremes, code three, clear
        add_req(sspl_pkg::REQ_LOOKUP, 32'h0, 32'h0);
        add_req(sspl_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(sspl_pkg::REQ_CLEAR, 32'h0, 32'h0);
        add_req(sspl_pkg::REQ_LOAD, 32'h0000_1000, 32'h1111_1111);
        add_req(sspl_pkg::REQ_LOAD, 32'h0000_1000, 32'h2222_2222);
        add_req(sspl_pkg::REQ_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(sspl_pkg::REQ_LOOKUP, 32'h0000_0FFF, 32'h0);
        add_req(sspl_pkg::REQ_LOOKUP, 32'h0000_1000, 32'h0);
        add_req(sspl_pkg::REQ_LOOKUP, 32'h0000_1004, 32'h0);
        add_req(sspl_pkg::REQ_LOOKUP_ALT, 32'h0000_2000, 32'h0);
        add_req(sspl_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        add_req(sspl_pkg::REQ_LOOKUP, 32'hFFFF_FFFE, 32'h0);
        add_req(sspl_pkg::REQ_LOAD, 32'h0, 32'h5555_5555);
        add_req(sspl_pkg::REQ_LOOKUP, 32'h0, 32'h0);
        add_req(sspl_pkg::REQ_LOAD, 32'h8000_0000, 32'hAAAA_AAAA);
        add_req(sspl_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_req(sspl_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(sspl_pkg::REQ_LOOKUP, 32'h0000_1000, 32'h0);
        add_req(sspl_pkg::REQ_LOAD, 32'hAAAA_AAAA, 32'h5555_5555);
        add_req(sspl_pkg::REQ_LOOKUP_ALT, 32'hFFFF_FFFF, 32'h0);
        add_req(sspl_pkg::REQ_CLEAR, 32'h0, 32'h0);

        // Random: mostly clear-load-lookup sequences, one fill past capacity
        target = req_backlog.size() + 850;
        filled = 0;
        while (req_backlog.size() < target) begin
            if (!filled && req_backlog.size() > 250) begin
                add_req(sspl_pkg::REQ_CLEAR, $urandom, $urandom);
                for (i = 0; i < ENTRIES + 3; i++)
                    add_req(sspl_pkg::REQ_LOAD, pick_key(), $urandom);
                for (i = 0; i < 12; i++) add_req(probe_code(), pick_probe(), $urandom);
                add_req(sspl_pkg::REQ_LOAD, pick_key(), $urandom);
                add_req(sspl_pkg::REQ_CLEAR, $urandom, $urandom);
                filled = 1;
            end else if ($urandom_range(99) < 8) begin
                add_req(2'($urandom_range(3)), $urandom, $urandom);
            end else begin
                if ($urandom_range(9) < 7) add_req(sspl_pkg::REQ_CLEAR, $urandom, $urandom);
                nload = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
                for (i = 0; i < nload; i++) add_req(sspl_pkg::REQ_LOAD, pick_key(), $urandom);
                nprobe = $urandom_range(4, 20);
                for (i = 0; i < nprobe; i++) begin
                    if ($urandom_range(3) == 0)
                        add_req(sspl_pkg::REQ_LOAD, pick_key(), $urandom);
                    else
                        add_req(probe_code(), pick_probe(), $urandom);
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || i_valid || pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && pending_outcomes.size() == 0) begin
            $display("[sorted_symbol_predecessor_lookup] OK");
        end else begin
            $display("[sorted_symbol_predecessor_lookup] ERROR");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("[sorted_symbol_predecessor_lookup] ERROR");
        $finish;
    end

endmodule
